// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the serial frame deframer
// Phases, result codes, register indexes, result word layout and the
// CRC 0x8005 word-advance function.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int BYTE_W     = 8;
   localparam int CRC_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int RSP_DEPTH  = 4;
   localparam int RSP_PTR_W  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   localparam logic [CRC_W-1:0]  CRC_POLY      = 16'h8005;
   localparam logic [BYTE_W-1:0] OLD_CMD_LIMIT = 8'h80;
   localparam logic [BYTE_W-1:0] OLD_CMD_ALT   = 8'hC4;

   localparam logic [BYTE_W-1:0] START_RESET  = 8'h02;
   localparam logic [BYTE_W-1:0] END_RESET    = 8'h03;
   localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h10;
   localparam logic [BYTE_W-1:0] ACK_RESET    = 8'h06;
   localparam logic [BYTE_W-1:0] NAK_RESET    = 8'h15;

   typedef enum logic [2:0] {
      PH_HUNT  = 3'd0,
      PH_CMD   = 3'd1,
      PH_OLD   = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CRCHI = 3'd5,
      PH_CRCLO = 3'd6,
      PH_SKIP  = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_NAK     = 2'd2,
      KIND_STATUS  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NO_START = 2'd1,
      STAT_BAD_CRC  = 2'd2,
      STAT_TRUNC    = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START  = 3'd0,
      CSR_END    = 3'd1,
      CSR_ESCAPE = 3'd2,
      CSR_ACK    = 3'd3,
      CSR_NAK    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] start_code;
      logic [BYTE_W-1:0] end_code;
      logic [BYTE_W-1:0] escape_code;
      logic [BYTE_W-1:0] ack_code;
      logic [BYTE_W-1:0] nak_code;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      kind_type          item_kind;
      status_type        frame_status;
      logic              frame_last;
   } rsp_type;

   // results of one accepted byte, in order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } step_type;

   typedef logic [CRC_W-1:0] crc_cols_type [CRC_W];

   // column i holds x^(16+i) mod P: the register after 16 zero shifts
   function automatic crc_cols_type crc_cols_gen();
      crc_cols_type     cols;
      logic [CRC_W-1:0] r;
      for (int i = 0; i < CRC_W; i++) begin
         r    = '0;
         r[i] = 1'b1;
         for (int k = 0; k < CRC_W; k++) begin
            if (r[CRC_W-1]) begin
               r = (r << 1) ^ CRC_POLY;
            end else begin
               r = r << 1;
            end
         end
         cols[i] = r;
      end
      return cols;
   endfunction

   localparam crc_cols_type CRC_COLS = crc_cols_gen();

   // 16 shift steps of the register with zero data, as one XOR matrix
   function automatic logic [CRC_W-1:0] crc_adv(input logic [CRC_W-1:0] v);
      logic [CRC_W-1:0] acc;
      acc = '0;
      for (int i = 0; i < CRC_W; i++) begin
         if (v[i]) begin
            acc = acc ^ CRC_COLS[i];
         end
      end
      return acc;
   endfunction

   function automatic rsp_type rsp_make(input logic [BYTE_W-1:0] b,
                                        input kind_type k,
                                        input status_type s,
                                        input logic last);
      rsp_type r;
      r.out_byte     = b;
      r.item_kind    = k;
      r.frame_status = s;
      r.frame_last   = last;
      return r;
   endfunction

endpackage

// ===== rtl/core/sfd_csr.sv =====
// ----------------------------------------------------------------------------
// sfd_csr: framing code registers
// Five byte-wide code registers, written one word per handshake.
// ----------------------------------------------------------------------------
module sfd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfd_pkg::BYTE_W-1:0]     csr_data,
   output sfd_pkg::cfg_type               cfg
);

   sfd_pkg::cfg_type cfg_ff;
   sfd_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            sfd_pkg::CSR_START:  cfg_in.start_code  = csr_data;
            sfd_pkg::CSR_END:    cfg_in.end_code    = csr_data;
            sfd_pkg::CSR_ESCAPE: cfg_in.escape_code = csr_data;
            sfd_pkg::CSR_ACK:    cfg_in.ack_code    = csr_data;
            sfd_pkg::CSR_NAK:    cfg_in.nak_code    = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_code  <= sfd_pkg::START_RESET;
         cfg_ff.end_code    <= sfd_pkg::END_RESET;
         cfg_ff.escape_code <= sfd_pkg::ESCAPE_RESET;
         cfg_ff.ack_code    <= sfd_pkg::ACK_RESET;
         cfg_ff.nak_code    <= sfd_pkg::NAK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/core/sfd_parser.sv =====
// ----------------------------------------------------------------------------
// sfd_parser: frame parser and CRC accumulator
// Tracks the phase, drops escapes in old-command frames, counts data, folds
// bytes into the running CRC; gives up to two result words per received byte.
// ----------------------------------------------------------------------------
module sfd_parser (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [sfd_pkg::BYTE_W-1:0]  rx_byte,
   input  logic                        chunk_end,
   input  sfd_pkg::cfg_type            cfg,
   output sfd_pkg::step_type           step
);

   sfd_pkg::phase_type             phase_ff, phase_in;
   logic [sfd_pkg::CRC_W-1:0]      crc_ff, crc_in;
   logic [sfd_pkg::BYTE_W-1:0]     pending_ff, pending_in;
   logic                           half_ff, half_in;
   logic [sfd_pkg::BYTE_W-1:0]     left_ff, left_in;
   logic [sfd_pkg::BYTE_W-1:0]     crc_high_ff, crc_high_in;

   logic is_start, is_ack, is_nak, is_end, is_esc, old_cmd;
   logic [sfd_pkg::CRC_W-1:0]  byte_crc, fin_crc;
   logic [sfd_pkg::BYTE_W-1:0] byte_pending;
   logic                       byte_half;
   sfd_pkg::rsp_type           payload_rsp, trunc_rsp, ok_rsp, no_start_rsp;

   assign is_start = (rx_byte == cfg.start_code);
   assign is_ack   = (rx_byte == cfg.ack_code);
   assign is_nak   = (rx_byte == cfg.nak_code);
   assign is_end   = (rx_byte == cfg.end_code);
   assign is_esc   = (rx_byte == cfg.escape_code);
   assign old_cmd  = (rx_byte < sfd_pkg::OLD_CMD_LIMIT) ||
                     (rx_byte == sfd_pkg::OLD_CMD_ALT);

   // pair bytes into words; a full word advances the register
   always_comb begin
      if (!half_ff) begin
         byte_crc     = crc_ff;
         byte_pending = rx_byte;
         byte_half    = 1'b1;
      end else begin
         byte_crc     = sfd_pkg::crc_adv(crc_ff) ^ {pending_ff, rx_byte};
         byte_pending = pending_ff;
         byte_half    = 1'b0;
      end
      // close the string: pad an odd byte, or shift in one zero word
      fin_crc = sfd_pkg::crc_adv(byte_crc) ^
                (byte_half ? {byte_pending, 8'h00} : 16'h0000);
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      crc_in      = crc_ff;
      pending_in  = pending_ff;
      half_in     = half_ff;
      left_in     = left_ff;
      crc_high_in = crc_high_ff;
      unique case (phase_ff)
         sfd_pkg::PH_HUNT: begin
            if (is_start) begin
               crc_in      = '0;
               pending_in  = '0;
               half_in     = 1'b0;
               left_in     = '0;
               crc_high_in = '0;
               phase_in    = sfd_pkg::PH_CMD;
            end else if (is_ack || is_nak) begin
               phase_in = sfd_pkg::PH_SKIP;
            end
         end
         sfd_pkg::PH_CMD: begin
            if (old_cmd) begin
               phase_in = is_end ? sfd_pkg::PH_SKIP : sfd_pkg::PH_OLD;
            end else begin
               crc_in     = byte_crc;
               pending_in = byte_pending;
               half_in    = byte_half;
               phase_in   = sfd_pkg::PH_LEN;
            end
         end
         sfd_pkg::PH_OLD: begin
            if (is_end) begin
               phase_in = sfd_pkg::PH_SKIP;
            end
         end
         sfd_pkg::PH_LEN: begin
            crc_in     = byte_crc;
            pending_in = byte_pending;
            half_in    = byte_half;
            left_in    = rx_byte;
            phase_in   = (rx_byte == '0) ? sfd_pkg::PH_CRCHI : sfd_pkg::PH_DATA;
         end
         sfd_pkg::PH_DATA: begin
            left_in = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               crc_in     = fin_crc;
               pending_in = byte_pending;
               half_in    = 1'b0;
               phase_in   = sfd_pkg::PH_CRCHI;
            end else begin
               crc_in     = byte_crc;
               pending_in = byte_pending;
               half_in    = byte_half;
            end
         end
         sfd_pkg::PH_CRCHI: begin
            crc_high_in = rx_byte;
            phase_in    = sfd_pkg::PH_CRCLO;
         end
         sfd_pkg::PH_CRCLO: begin
            phase_in = sfd_pkg::PH_SKIP;
         end
         sfd_pkg::PH_SKIP: begin
            phase_in = phase_ff;
         end
         default: begin
            phase_in = sfd_pkg::PH_HUNT;
         end
      endcase
      if (chunk_end) begin
         phase_in = sfd_pkg::PH_HUNT;
      end
   end

   // result words
   always_comb begin
      payload_rsp  = sfd_pkg::rsp_make(rx_byte, sfd_pkg::KIND_PAYLOAD,
                                       sfd_pkg::STAT_OK, 1'b0);
      trunc_rsp    = sfd_pkg::rsp_make(8'h00, sfd_pkg::KIND_STATUS,
                                       sfd_pkg::STAT_TRUNC, 1'b1);
      ok_rsp       = sfd_pkg::rsp_make(8'h00, sfd_pkg::KIND_STATUS,
                                       sfd_pkg::STAT_OK, 1'b1);
      no_start_rsp = sfd_pkg::rsp_make(8'h00, sfd_pkg::KIND_STATUS,
                                       sfd_pkg::STAT_NO_START, 1'b1);
      step.count  = 2'd0;
      step.first  = payload_rsp;
      step.second = trunc_rsp;
      unique case (phase_ff)
         sfd_pkg::PH_HUNT: begin
            if (is_start) begin
               step.first = no_start_rsp;
               step.count = chunk_end ? 2'd1 : 2'd0;
            end else if (is_ack || is_nak) begin
               step.first = sfd_pkg::rsp_make(rx_byte,
                               is_ack ? sfd_pkg::KIND_ACK : sfd_pkg::KIND_NAK,
                               sfd_pkg::STAT_OK, 1'b1);
               step.count = 2'd1;
            end else begin
               step.first = no_start_rsp;
               step.count = chunk_end ? 2'd1 : 2'd0;
            end
         end
         sfd_pkg::PH_CMD, sfd_pkg::PH_OLD: begin
            if ((phase_ff == sfd_pkg::PH_OLD) || old_cmd) begin
               priority if (is_end) begin
                  step.first = ok_rsp;
                  step.count = 2'd1;
               end else if (!is_esc) begin
                  step.second = ok_rsp;
                  step.count  = chunk_end ? 2'd2 : 2'd1;
               end else begin
                  // drop the escape byte
                  step.first = ok_rsp;
                  step.count = chunk_end ? 2'd1 : 2'd0;
               end
            end else begin
               step.count = chunk_end ? 2'd2 : 2'd1;
            end
         end
         sfd_pkg::PH_LEN, sfd_pkg::PH_DATA: begin
            step.count = chunk_end ? 2'd2 : 2'd1;
         end
         sfd_pkg::PH_CRCHI: begin
            step.first = trunc_rsp;
            step.count = chunk_end ? 2'd1 : 2'd0;
         end
         sfd_pkg::PH_CRCLO: begin
            step.first = sfd_pkg::rsp_make(8'h00, sfd_pkg::KIND_STATUS,
                            ({crc_high_ff, rx_byte} == crc_ff) ?
                            sfd_pkg::STAT_OK : sfd_pkg::STAT_BAD_CRC, 1'b1);
            step.count = 2'd1;
         end
         sfd_pkg::PH_SKIP: begin
            step.count = 2'd0;
         end
         default: begin
            step.count = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sfd_pkg::PH_HUNT;
         crc_ff      <= '0;
         pending_ff  <= '0;
         half_ff     <= 1'b0;
         left_ff     <= '0;
         crc_high_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         crc_ff      <= crc_in;
         pending_ff  <= pending_in;
         half_ff     <= half_in;
         left_ff     <= left_in;
         crc_high_ff <= crc_high_in;
      end
   end

endmodule

// ===== rtl/core/sfd_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// sfd_rsp_fifo: result word queue
// Takes up to two words per cycle from the parser and hands out one word
// per handshake; asks for room for two words before taking a byte.
// ----------------------------------------------------------------------------
module sfd_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfd_pkg::step_type    step,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sfd_pkg::rsp_type     rsp
);

   sfd_pkg::rsp_type                mem_ff [sfd_pkg::RSP_DEPTH];
   logic [sfd_pkg::RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sfd_pkg::RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sfd_pkg::RSP_CNT_W-1:0]   count_ff, count_in;
   logic [sfd_pkg::RSP_PTR_W-1:0]   wr_next;
   logic [1:0]                      n_push;
   logic                            pop;

   assign room      = (count_ff <= sfd_pkg::RSP_CNT_W'(sfd_pkg::RSP_DEPTH - 2));
   assign rsp_valid = (count_ff != '0);
   assign rsp       = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign n_push    = push ? step.count : 2'd0;
   assign wr_next   = wr_ptr_ff + sfd_pkg::RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + sfd_pkg::RSP_PTR_W'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + sfd_pkg::RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + sfd_pkg::RSP_CNT_W'(n_push)
                  - sfd_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem_ff[wr_ptr_ff] <= step.first;
      end
      if (n_push == 2'd2) begin
         mem_ff[wr_next] <= step.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/serial_frame_deframer_crc.sv =====
// ----------------------------------------------------------------------------
// serial_frame_deframer_crc: start/end/escape deframer with CRC 0x8005 check
// Results: a byte's results go into the four-word result queue as the byte
// is taken and are offered behind any earlier words. Throughput: one byte
// per cycle while the queue has room for two words; one word per handshake.
// Reset: synchronous; back to hunting with empty queue and default codes.
// ----------------------------------------------------------------------------
module serial_frame_deframer_crc (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sfd_pkg::BYTE_W-1:0]     req_rx_byte,
   input  logic                           req_chunk_end,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sfd_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic [1:0]                     rsp_item_kind,
   output logic [1:0]                     rsp_frame_status,
   output logic                           rsp_frame_last,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfd_pkg::BYTE_W-1:0]     csr_data
);

   sfd_pkg::cfg_type  cfg;
   sfd_pkg::step_type step;
   sfd_pkg::rsp_type  rsp;
   logic              room;
   logic              accept;

   assign req_ready = room;
   assign accept    = req_valid && room;

   sfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .chunk_end (req_chunk_end),
      .cfg       (cfg),
      .step      (step)
   );

   sfd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .step      (step),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_out_byte     = rsp.out_byte;
   assign rsp_item_kind    = rsp.item_kind;
   assign rsp_frame_status = rsp.frame_status;
   assign rsp_frame_last   = rsp.frame_last;

endmodule
